[hdl/spq_pkg.sv]
// spq_pkg: shared types and codes for the sorted priority queue
// entry record, per-cell control, result record, operation and status codes
// no dependencies
package spq_pkg;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] burst;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    typedef struct packed {
        logic        queue_empty;
        status_t     status;
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] burst;
    } result_t;

endpackage

[hdl/spq_cell.sv]
// spq_cell: one slot of the sorted queue chain
// compares its entry with the incoming one and shifts toward either neighbor
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  logic       valid,
    input  logic       left_ahead,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output logic       ahead,
    output entry_t     entry,
    output entry_t     entry_next
);

    entry_t entry_reg;

    // stored entry stays in front of the new one
    assign ahead = valid && ((entry_reg.prio < new_entry.prio) ||
                   ((entry_reg.prio == new_entry.prio) && (entry_reg.id < new_entry.id)));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (ahead)
                entry_next = entry_reg;
            else if (left_ahead)
                entry_next = new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[hdl/sorted_priority_queue.sv]
// sorted_priority_queue: top level, a chain of slot cells kept in priority order
// result on m_axis is registered, going to the skid register when the output register holds an untaken result
// throughput: one transaction per cycle; s_axis_tready drops only when both output
//   register and skid register hold results
// reset clears the entry count and output valids; slot contents are not cleared
// depends on spq_pkg and spq_cell
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // task_id, arrival_time, burst_length, prio_level
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // head_id, head_arrival, head_burst
    output logic [2:0]  m_axis_tuser    // queue_empty, op_status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    result_t       out_reg, out_next;
    result_t       skid_reg, skid_next;

    logic       s_fire, m_fire, full, empty;
    func_t      func;
    entry_t     new_entry;
    cell_ctrl_t ctrl;
    status_t    status;
    result_t    res;

    entry_t     cell_entry [QUEUE_DEPTH];
    entry_t     cell_next  [QUEUE_DEPTH];
    logic       cell_ahead [QUEUE_DEPTH];

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign func   = func_t'(s_axis_tuser);

    assign new_entry.id      = s_axis_tdata[15:0];
    assign new_entry.arrival = s_axis_tdata[31:16];
    assign new_entry.burst   = s_axis_tdata[47:32];
    assign new_entry.prio    = s_axis_tdata[55:48];

    always_comb
    begin
        ctrl       = '0;
        status     = STAT_OK;
        count_next = count_reg;
        if (s_fire)
        begin
            unique case (func)
                FUNC_INSERT:
                begin
                    if (full)
                        status = STAT_FULL;
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                FUNC_POP:
                begin
                    if (empty)
                        status = STAT_EMPTY;
                    else
                    begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: status = STAT_OK;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            logic   left_ahead;
            entry_t left_entry;
            entry_t right_entry;

            if (k == 0)
            begin : g_first
                assign left_ahead = 1'b1;
                assign left_entry = new_entry;
            end
            else
            begin : g_mid
                assign left_ahead = cell_ahead[k-1];
                assign left_entry = cell_entry[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_entry = cell_entry[k];
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[k+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .valid       (CW'(k) < count_reg),
                .left_ahead  (left_ahead),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .ahead       (cell_ahead[k]),
                .entry       (cell_entry[k]),
                .entry_next  (cell_next[k])
            );
        end
    endgenerate

    always_comb
    begin
        res.queue_empty = (count_next == '0);
        res.status      = status;
        res.id          = res.queue_empty ? 16'd0 : cell_next[0].id;
        res.arrival     = res.queue_empty ? 16'd0 : cell_next[0].arrival;
        res.burst       = res.queue_empty ? 16'd0 : cell_next[0].burst;
    end

    // output register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (m_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (s_fire)
                out_next = res;
            else
                out_valid_next = 1'b0;
        end
        else if (s_fire)
        begin
            if (!out_valid_reg)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.burst, out_reg.arrival, out_reg.id};
    assign m_axis_tuser  = {out_reg.status, out_reg.queue_empty};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (func == FUNC_INSERT) && full |=> count_reg == $past(count_reg))
        else $error("insert into full queue changed the count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (func == FUNC_POP) && !empty |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove one entry");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

endmodule
